### rtl/wfm_pkg.sv
// Shared types, codes and constants for the wall-follower maze walker.
package wfm_pkg;

  // Geometry of the stored wall map and the default grid size
  localparam int GRID_SIDE_DEFAULT = 16;
  localparam int MAP_SIDE          = 16;
  localparam int COORD_W           = 4;
  localparam int MAP_DEPTH         = MAP_SIDE * MAP_SIDE;
  localparam int MAP_ADDR_W        = 2 * COORD_W;
  localparam int COUNT_W           = 16;
  localparam int NUM_DIRS          = 4;

  // Configuration port shape
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 4;

  // Item opcodes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_START_ROW     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_COL     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_HEADING = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_ROW      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXIT_COL      = 3'd4;

  // Headings
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // Relative turns added to the heading
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_BACK  = 2'd2;
  localparam logic [1:0] TURN_LEFT  = 2'd3;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_START_ROW     = 4'd2;
  localparam logic [COORD_W-1:0] RST_START_COL     = 4'd0;
  localparam logic [1:0]         RST_START_HEADING = DIR_EAST;
  localparam logic [COORD_W-1:0] RST_EXIT_ROW      = 4'd4;
  localparam logic [COORD_W-1:0] RST_EXIT_COL      = 4'd11;

  // Input beat
  typedef struct packed {
    logic [1:0]         opcode;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               cell_is_wall;
  } item_t;

  // Output beat
  typedef struct packed {
    logic [COORD_W-1:0] pos_row;
    logic [COORD_W-1:0] pos_col;
    logic [COUNT_W-1:0] step_count;
    logic               reached_exit;
  } result_t;

endpackage

### rtl/wfm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wfm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wall_follower_maze_step.sv
// Top level of the right-hand wall-follower maze walker.
// A step beat passes through the input register and then the result register on its way out.
// Throughput: one item per cycle while the result register has room for a step; the four neighbor
// walls come from RAM copies read in advance at the walker's next position, with write bypass.
// Reset (synchronous, active high) restores the registers and walker to their
// reset values; the wall map is not cleared and holds garbage until written.
module wall_follower_maze_step #(
  parameter int GRID_SIDE = wfm_pkg::GRID_SIDE_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  wfm_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output wfm_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [wfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = wfm_pkg::COORD_W;
  localparam int EFF_SIDE = (GRID_SIDE < wfm_pkg::MAP_SIDE) ? GRID_SIDE : wfm_pkg::MAP_SIDE;
  localparam logic [CW:0] EFF_LIMIT = EFF_SIDE[CW:0];

  // Configuration registers
  logic [CW-1:0] start_row, start_col, exit_row, exit_col;
  logic [1:0]    start_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row     <= wfm_pkg::RST_START_ROW;
      start_col     <= wfm_pkg::RST_START_COL;
      start_heading <= wfm_pkg::RST_START_HEADING;
      exit_row      <= wfm_pkg::RST_EXIT_ROW;
      exit_col      <= wfm_pkg::RST_EXIT_COL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wfm_pkg::CFG_START_ROW:     start_row     <= cfg_data[CW-1:0];
        wfm_pkg::CFG_START_COL:     start_col     <= cfg_data[CW-1:0];
        wfm_pkg::CFG_START_HEADING: start_heading <= cfg_data[1:0];
        wfm_pkg::CFG_EXIT_ROW:      exit_row      <= cfg_data[CW-1:0];
        wfm_pkg::CFG_EXIT_COL:      exit_col      <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic           iq_valid;
  wfm_pkg::item_t iq;
  logic           iq_is_step, iq_go;

  assign iq_is_step = (iq.opcode == wfm_pkg::OP_STEP);
  // Only a step needs room in the result register
  assign iq_go      = iq_valid && (!iq_is_step || !result_valid || result_ready);
  assign item_ready = !iq_valid || iq_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (item_ready) begin
      iq_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      iq <= item;
    end
  end

  // Walker state
  logic [CW-1:0]               walker_row, walker_col;
  logic [1:0]                  heading;
  logic [wfm_pkg::COUNT_W-1:0] moves_made;
  logic                        finished;
  logic [CW-1:0]               walker_row_next, walker_col_next;
  logic [1:0]                  heading_next;
  logic [wfm_pkg::COUNT_W-1:0] moves_made_next;
  logic                        finished_next;

  // Neighbor walls: RAM data, overridden by a write in the previous cycle
  logic [wfm_pkg::NUM_DIRS-1:0] ram_q, hit_q;
  logic                         wbit_q;
  logic [wfm_pkg::NUM_DIRS-1:0] hit;
  logic [wfm_pkg::MAP_ADDR_W-1:0] raddr [wfm_pkg::NUM_DIRS];
  logic                           ram_we;
  logic [wfm_pkg::MAP_ADDR_W-1:0] waddr;

  assign ram_we = iq_go && (iq.opcode == wfm_pkg::OP_WRITE);
  assign waddr  = {iq.cell_row, iq.cell_col};

  // Neighbor cells of the current position, one guard bit for the grid test
  logic [CW:0]                  nbr_row [wfm_pkg::NUM_DIRS];
  logic [CW:0]                  nbr_col [wfm_pkg::NUM_DIRS];
  logic [wfm_pkg::NUM_DIRS-1:0] inb, wall, open;

  always_comb begin
    nbr_row[wfm_pkg::DIR_NORTH] = {1'b0, walker_row} - 1'b1;
    nbr_col[wfm_pkg::DIR_NORTH] = {1'b0, walker_col};
    nbr_row[wfm_pkg::DIR_EAST]  = {1'b0, walker_row};
    nbr_col[wfm_pkg::DIR_EAST]  = {1'b0, walker_col} + 1'b1;
    nbr_row[wfm_pkg::DIR_SOUTH] = {1'b0, walker_row} + 1'b1;
    nbr_col[wfm_pkg::DIR_SOUTH] = {1'b0, walker_col};
    nbr_row[wfm_pkg::DIR_WEST]  = {1'b0, walker_row};
    nbr_col[wfm_pkg::DIR_WEST]  = {1'b0, walker_col} - 1'b1;
    for (int d = 0; d < wfm_pkg::NUM_DIRS; d++) begin
      // Going below zero wraps to a large value and fails the test as well
      inb[d]  = (nbr_row[d] < EFF_LIMIT) && (nbr_col[d] < EFF_LIMIT);
      wall[d] = hit_q[d] ? wbit_q : ram_q[d];
      open[d] = inb[d] && !wall[d];
    end
  end

  // Move choice: first step straight, then right, front, left, back
  logic [1:0] dir_r, dir_l, dir_b, move_dir;
  logic       take_move;

  assign dir_r = heading + wfm_pkg::TURN_RIGHT;
  assign dir_l = heading + wfm_pkg::TURN_LEFT;
  assign dir_b = heading + wfm_pkg::TURN_BACK;

  always_comb begin
    take_move = 1'b0;
    move_dir  = heading;
    if (finished) begin
      take_move = 1'b0;
    end else if (moves_made == '0) begin
      take_move = inb[heading];
    end else if (open[dir_r]) begin
      take_move = 1'b1;
      move_dir  = dir_r;
    end else if (open[heading]) begin
      take_move = 1'b1;
    end else if (open[dir_l]) begin
      take_move = 1'b1;
      move_dir  = dir_l;
    end else begin
      take_move = inb[dir_b];
      move_dir  = dir_b;
    end
  end

  // Walker next state
  always_comb begin
    walker_row_next = walker_row;
    walker_col_next = walker_col;
    heading_next    = heading;
    moves_made_next = moves_made;
    finished_next   = finished;
    if (iq_go) begin
      unique case (iq.opcode)
        wfm_pkg::OP_RESTART: begin
          walker_row_next = start_row;
          walker_col_next = start_col;
          heading_next    = start_heading;
          moves_made_next = '0;
          finished_next   = (start_row == exit_row) && (start_col == exit_col);
        end
        wfm_pkg::OP_STEP: begin
          if (take_move) begin
            walker_row_next = nbr_row[move_dir][CW-1:0];
            walker_col_next = nbr_col[move_dir][CW-1:0];
            heading_next    = move_dir;
            if (moves_made != '1) begin
              moves_made_next = moves_made + 1'b1;
            end
            finished_next = (nbr_row[move_dir][CW-1:0] == exit_row) &&
                            (nbr_col[move_dir][CW-1:0] == exit_col);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walker_row <= wfm_pkg::RST_START_ROW;
      walker_col <= wfm_pkg::RST_START_COL;
      heading    <= wfm_pkg::RST_START_HEADING;
      moves_made <= '0;
      finished   <= 1'b0;
    end else begin
      walker_row <= walker_row_next;
      walker_col <= walker_col_next;
      heading    <= heading_next;
      moves_made <= moves_made_next;
      finished   <= finished_next;
    end
  end

  // Read addresses: neighbors of the position the walker holds next cycle
  always_comb begin
    raddr[wfm_pkg::DIR_NORTH] = {walker_row_next - 1'b1, walker_col_next};
    raddr[wfm_pkg::DIR_EAST]  = {walker_row_next, walker_col_next + 1'b1};
    raddr[wfm_pkg::DIR_SOUTH] = {walker_row_next + 1'b1, walker_col_next};
    raddr[wfm_pkg::DIR_WEST]  = {walker_row_next, walker_col_next - 1'b1};
    for (int d = 0; d < wfm_pkg::NUM_DIRS; d++) begin
      hit[d] = ram_we && (waddr == raddr[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= '0;
    end else begin
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk) begin
    wbit_q <= iq.cell_is_wall;
  end

  // One copy of the wall map per compass neighbor
  for (genvar d = 0; d < wfm_pkg::NUM_DIRS; d++) begin : g_map
    wfm_ram #(
      .WIDTH (1),
      .DEPTH (wfm_pkg::MAP_DEPTH)
    ) u_map (
      .clk   (clk),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (iq.cell_is_wall),
      .raddr (raddr[d]),
      .rdata (ram_q[d])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (iq_go && iq_is_step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (iq_go && iq_is_step) begin
      result.pos_row      <= walker_row_next;
      result.pos_col      <= walker_col_next;
      result.step_count   <= moves_made_next;
      result.reached_exit <= finished_next;
    end
  end

endmodule

### rtl/wfm_checker.sv
// Port-level checks for the maze walker, bound to the top level.
module wfm_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input wfm_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_ready,
  input wfm_pkg::result_t result
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A fresh result comes from a step beat accepted at the input
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |->
      $past(item_valid && item_ready && (item.opcode == wfm_pkg::OP_STEP), 2))
    else $error("result without a preceding step beat");

  // Input never stalls while the output side is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty result register");

  // A stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

endmodule

bind wall_follower_maze_step wfm_checker u_wfm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
